// File: rtl/core/mvt_pkg.sv
package mvt_pkg;

    // Fixed shape of the stream payload.
    localparam int MAX_DIM    = 4;
    localparam int ELEM_W     = 32;
    localparam int DATA_W     = MAX_DIM * ELEM_W;
    localparam int IN_USER_W  = 3;
    localparam int OUT_USER_W = 1;

    // Arithmetic widths: exact product, pair sum, total with rounding headroom.
    localparam int PROD_W = 2 * ELEM_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;

    // Operation codes carried in the low tuser bit.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    typedef logic signed [ELEM_W-1:0] elem_t;

    // Load enables for the pipeline stages, from first to last.
    typedef struct packed {
        logic prod_en;
        logic pair_en;
        logic sum_en;
        logic out_en;
    } stage_en_t;

endpackage

// File: rtl/core/mvt_lane.sv
module mvt_lane
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int DIM       = 4
)
(
    input  logic      clk,
    input  stage_en_t en,
    input  elem_t     row_elems [MAX_DIM],
    input  elem_t     vec_elems [MAX_DIM],
    output elem_t     value,
    output logic      sat
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg [MAX_DIM];
    logic signed [PAIR_W-1:0] pair_lo_reg;
    logic signed [PAIR_W-1:0] pair_hi_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  shifted;
    logic                     pos_ovf;
    logic                     neg_ovf;

    // One multiplier per element; elements beyond the matrix size contribute zero.
    for (genvar c = 0; c < MAX_DIM; c++)
    begin : g_mul
        if (c < DIM)
        begin : g_used
            always_ff @(posedge clk)
            begin
                if (en.prod_en)
                begin
                    prod_reg[c] <= row_elems[c] * vec_elems[c];
                end
            end
        end
        else
        begin : g_unused
            assign prod_reg[c] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.pair_en)
        begin
            pair_lo_reg <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_hi_reg <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
        if (en.sum_en)
        begin
            sum_reg <= SUM_W'(pair_lo_reg) + SUM_W'(pair_hi_reg) + ROUND_HALF;
        end
    end

    // Floor after adding half an LSB gives round to nearest, halves upward.
    assign shifted = sum_reg >>> FRAC_BITS;
    assign pos_ovf = !shifted[SUM_W-1] && (|shifted[SUM_W-2:ELEM_W-1]);
    assign neg_ovf = shifted[SUM_W-1] && !(&shifted[SUM_W-2:ELEM_W-1]);

    always_comb
    begin
        if (pos_ovf)
        begin
            value = {1'b0, {(ELEM_W-1){1'b1}}};
        end
        else if (neg_ovf)
        begin
            value = {1'b1, {(ELEM_W-1){1'b0}}};
        end
        else
        begin
            value = shifted[ELEM_W-1:0];
        end
    end

    assign sat = pos_ovf || neg_ovf;

endmodule

// File: rtl/core/mvt_ctrl.sv
module mvt_ctrl
    import mvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_xform,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output stage_en_t en
);

    localparam int NSTAGE = 4;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] free;

    // A stage may load when it is empty or its content moves on this cycle,
    // so bubbles are squeezed out even while the output is stalled.
    always_comb
    begin
        free[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            free[i] = !valid_reg[i] || free[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (free[0])
        begin
            valid_next[0] = in_valid && (in_xform == MODE_XFORM);
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (free[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en.prod_en = free[0];
    assign en.pair_en = free[1];
    assign en.sum_en  = free[2];
    assign en.out_en  = free[3];
    assign in_ready   = free[0];
    assign out_valid  = valid_reg[NSTAGE-1];

endmodule

// File: rtl/core/mat4_vector_transform_unit.sv
// Matrix by vector transform unit, signed fixed point with FRAC_BITS fraction bits.
// The slave channel carries two kinds of transaction, chosen by s_axis_tuser[0].
// A load (tuser[0] = 0) writes row tuser[2:1] of the matrix from the four tdata
// elements and produces no output; rows and elements at or beyond DIM are dropped.
// A transform (tuser[0] = 1) carries a vector in tdata and produces one master
// transaction: the dot product of every matrix row with that vector, each rounded
// to nearest (halves up) and saturated to 32 bits, with m_axis_tuser[0] set when
// any of them was clipped. Outputs for rows at or beyond DIM are zero.
// From the accepting edge, the product registers load first, then the pair sums, the
// total with rounding and the output register, after which m_axis_tvalid rises. One
// transaction per cycle is accepted in steady state while the receiver keeps up;
// each row lane has its own DIM 32x32 multipliers, one per element below DIM.
// A load takes effect for a transform accepted in the very next cycle.
// When the receiver stalls, the pipeline keeps filling its empty stages, and
// s_axis_tready drops only once all four stages hold results.
// Reset clears the matrix to zero and empties the pipeline.
module mat4_vector_transform_unit
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int DIM       = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,  // elem0, elem1, elem2, elem3
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // mode, row_select[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,  // out0, out1, out2, out3
    output logic [OUT_USER_W-1:0] m_axis_tuser   // saturated
);

    elem_t     in_elems [MAX_DIM];
    elem_t     matrix_reg [DIM][MAX_DIM];
    elem_t     lane_val [MAX_DIM];
    logic      lane_sat [MAX_DIM];
    elem_t     out_val_reg [MAX_DIM];
    logic      out_sat_reg;
    logic      sat_any;
    logic      load_accept;
    logic      in_mode;
    logic [1:0] in_row;
    stage_en_t en;

    assign in_mode = s_axis_tuser[0];
    assign in_row  = s_axis_tuser[2:1];

    for (genvar c = 0; c < MAX_DIM; c++)
    begin : g_unpack
        assign in_elems[c] = s_axis_tdata[c*ELEM_W +: ELEM_W];
    end

    assign load_accept = s_axis_tvalid && s_axis_tready && (in_mode == MODE_LOAD);

    // Matrix storage: one register row per lane, written by a load transaction.
    for (genvar r = 0; r < DIM; r++)
    begin : g_row
        for (genvar c = 0; c < MAX_DIM; c++)
        begin : g_col
            if (c < DIM)
            begin : g_store
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        matrix_reg[r][c] <= '0;
                    end
                    else if (load_accept && (in_row == 2'(r)))
                    begin
                        matrix_reg[r][c] <= in_elems[c];
                    end
                end
            end
            else
            begin : g_none
                assign matrix_reg[r][c] = '0;
            end
        end
    end

    mvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_xform  (in_mode),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .en        (en)
    );

    // One lane per matrix row; unused rows read as zero with no clipping.
    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_lane
        if (k < DIM)
        begin : g_active
            mvt_lane #(
                .FRAC_BITS (FRAC_BITS),
                .DIM       (DIM)
            ) u_lane (
                .clk       (clk),
                .en        (en),
                .row_elems (matrix_reg[k]),
                .vec_elems (in_elems),
                .value     (lane_val[k]),
                .sat       (lane_sat[k])
            );
        end
        else
        begin : g_idle
            assign lane_val[k] = '0;
            assign lane_sat[k] = 1'b0;
        end
    end

    // Merge: the saturation flag is set when any lane clipped.
    always_comb
    begin
        sat_any = 1'b0;
        for (int k = 0; k < MAX_DIM; k++)
        begin
            sat_any = sat_any | lane_sat[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.out_en)
        begin
            out_val_reg <= lane_val;
            out_sat_reg <= sat_any;
        end
    end

    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_pack
        assign m_axis_tdata[k*ELEM_W +: ELEM_W] = out_val_reg[k];
    end

    assign m_axis_tuser = out_sat_reg;

`ifndef SYNTH
    // The input side only backs up when the output is both full and stalled.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the output could drain");

    // A clipped result always carries at least one limit value.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[31:0] == 32'h7FFFFFFF || m_axis_tdata[31:0] == 32'h80000000 ||
             m_axis_tdata[63:32] == 32'h7FFFFFFF || m_axis_tdata[63:32] == 32'h80000000 ||
             m_axis_tdata[95:64] == 32'h7FFFFFFF || m_axis_tdata[95:64] == 32'h80000000 ||
             m_axis_tdata[127:96] == 32'h7FFFFFFF || m_axis_tdata[127:96] == 32'h80000000))
        else $error("saturation flag without a clipped output");
`endif

endmodule
